// ===== rtl/core/bclc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the battery charge and load controller.
package bclc_pkg;

  localparam int RAW_W     = 12;
  localparam int VAL_W     = 15;
  localparam int DUTY_W    = 12;
  localparam int MA_W      = 12;
  localparam int WAIT_W    = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;

  // ADC scaling: val = (raw * M) >> SCALE_SHIFT, M = ceil(num * 2^SCALE_SHIFT / den)
  localparam int SCALE_SHIFT = 22;
  localparam int SCALE_M_W   = 25;
  localparam int PROD_W      = RAW_W + SCALE_M_W;
  localparam logic [SCALE_M_W-1:0] SCALE_M_V = SCALE_M_W'(
    (64'd4270 * (64'd1 << SCALE_SHIFT) + 64'd891) / 64'd892);
  localparam logic [SCALE_M_W-1:0] SCALE_M_C = SCALE_M_W'(
    (64'd3030 * (64'd1 << SCALE_SHIFT) + 64'd3579) / 64'd3580);
  localparam logic [SCALE_M_W-1:0] SCALE_M_D = SCALE_M_W'(
    (64'd1000 * (64'd1 << SCALE_SHIFT) + 64'd1899) / 64'd1900);

  // queue depth, power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_CHARGE = 2'd1;
  localparam logic [1:0] MODE_OFF    = 2'd2;
  localparam logic [1:0] MODE_LOAD   = 2'd3;

  localparam logic [1:0] KIND_NONE      = 2'd0;
  localparam logic [1:0] KIND_LITHIUM   = 2'd1;
  localparam logic [1:0] KIND_LEAD      = 2'd2;
  localparam logic [1:0] KIND_DISCHARGE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_TARGET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_TARGET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CV_HOLD       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLA_HOLD      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_WAIT   = 3'd5;

  localparam logic [DUTY_W-1:0] RST_PWM_PERIOD    = 12'd2400;
  localparam logic [MA_W-1:0]   RST_CHARGE_TARGET = 12'd1000;
  localparam logic [MA_W-1:0]   RST_LOAD_TARGET   = 12'd1000;
  localparam logic [DUTY_W-1:0] RST_CV_HOLD       = 12'd440;
  localparam logic [DUTY_W-1:0] RST_SLA_HOLD      = 12'd1450;
  localparam logic [WAIT_W-1:0] RST_DETECT_WAIT   = 9'd500;

  localparam logic [DUTY_W-1:0] CAP_OFFSET = 12'd1400;
  localparam logic [VAL_W-1:0]  V_DEAD     = 15'd1000;
  localparam logic [VAL_W-1:0]  I_DEAD     = 15'd200;
  localparam logic [VAL_W-1:0]  V_CC_MAX   = 15'd4000;
  localparam logic [VAL_W-1:0]  V_CV_LO    = 15'd4880;
  localparam logic [VAL_W-1:0]  V_CV_HI    = 15'd5000;
  localparam logic [VAL_W-1:0]  V_LI_MAX   = 15'd9000;
  localparam logic [VAL_W-1:0]  V_SLA_HI   = 15'd14778;
  localparam logic [VAL_W-1:0]  V_DETECT   = 15'd2000;
  localparam logic [VAL_W-1:0]  I_DETECT   = 15'd100;

  typedef struct packed {
    logic [DUTY_W-1:0] pwm_period;
    logic [MA_W-1:0]   charge_target;
    logic [MA_W-1:0]   load_target;
    logic [DUTY_W-1:0] cv_hold;
    logic [DUTY_W-1:0] sla_hold;
    logic [WAIT_W-1:0] detect_wait;
  } cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0] volt;
    logic [VAL_W-1:0] chg;
    logic [VAL_W-1:0] dis;
    logic [1:0]       mode;
    logic             clr_load;
    logic             clr_chg;
  } item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] charge_duty;
    logic [DUTY_W-1:0] load_duty;
    logic              present;
    logic [VAL_W-1:0]  avg_mv;
    logic [MA_W-1:0]   avg_chg;
    logic [MA_W-1:0]   avg_dis;
    logic [1:0]        kind;
  } result_t;

endpackage

// ===== rtl/core/battery_charge_load_controller.sv =====
`timescale 1ns / 1ps
// Top level of the battery charge and load controller.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_mode, in_raw_voltage, in_raw_*_current
// out      output     out_valid / out_ready  out_charge_duty .. out_display_kind
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// The ring RAM reads the old sample and then writes the new one for each item,
// so the back end takes a new item only after it has written the last one.
// Reset is synchronous; a fill flag makes unwritten ring slots read as zero,
// so there is no clearing pass and in_ready is high right after reset.
// A stalled output backs up through the result register, the averaging stage,
// the queue and the front register before in_ready drops.
module battery_charge_load_controller #(
  parameter int WINDOW_LOG2 = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_mode,
  input  logic [bclc_pkg::RAW_W-1:0]        in_raw_voltage,
  input  logic [bclc_pkg::RAW_W-1:0]        in_raw_charge_current,
  input  logic [bclc_pkg::RAW_W-1:0]        in_raw_discharge_current,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bclc_pkg::DUTY_W-1:0]       out_charge_duty,
  output logic [bclc_pkg::DUTY_W-1:0]       out_load_duty,
  output logic                              out_battery_present,
  output logic [bclc_pkg::VAL_W-1:0]        out_avg_millivolts,
  output logic [bclc_pkg::MA_W-1:0]         out_avg_charge_ma,
  output logic [bclc_pkg::MA_W-1:0]         out_avg_discharge_ma,
  output logic [1:0]                        out_display_kind,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bclc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bclc_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import bclc_pkg::*;

  cfg_t    cfg_r;
  item_t   q_in, q_head;
  result_t res;
  logic    q_push, q_pop, q_full, q_empty;
  logic    cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_period    <= RST_PWM_PERIOD;
      cfg_r.charge_target <= RST_CHARGE_TARGET;
      cfg_r.load_target   <= RST_LOAD_TARGET;
      cfg_r.cv_hold       <= RST_CV_HOLD;
      cfg_r.sla_hold      <= RST_SLA_HOLD;
      cfg_r.detect_wait   <= RST_DETECT_WAIT;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_PWM_PERIOD:    cfg_r.pwm_period    <= cfg_data;
        CFG_CHARGE_TARGET: cfg_r.charge_target <= cfg_data;
        CFG_LOAD_TARGET:   cfg_r.load_target   <= cfg_data;
        CFG_CV_HOLD:       cfg_r.cv_hold       <= cfg_data;
        CFG_SLA_HOLD:      cfg_r.sla_hold      <= cfg_data;
        CFG_DETECT_WAIT:   cfg_r.detect_wait   <= cfg_data[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  bclc_front u_front (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_mode                  (in_mode),
    .in_raw_voltage           (in_raw_voltage),
    .in_raw_charge_current    (in_raw_charge_current),
    .in_raw_discharge_current (in_raw_discharge_current),
    .q_full                   (q_full),
    .q_push                   (q_push),
    .q_item                   (q_in)
  );

  bclc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  bclc_back #(
    .WINDOW_LOG2 (WINDOW_LOG2)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_charge_duty      = res.charge_duty;
  assign out_load_duty        = res.load_duty;
  assign out_battery_present  = res.present;
  assign out_avg_millivolts   = res.avg_mv;
  assign out_avg_charge_ma    = res.avg_chg;
  assign out_avg_discharge_ma = res.avg_dis;
  assign out_display_kind     = res.kind;

endmodule

// ===== rtl/core/bclc_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module bclc_ram #(
  parameter int WIDTH = 45,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/bclc_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts items, scales ADC samples, classifies mode entry.
module bclc_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_mode,
  input  logic [bclc_pkg::RAW_W-1:0] in_raw_voltage,
  input  logic [bclc_pkg::RAW_W-1:0] in_raw_charge_current,
  input  logic [bclc_pkg::RAW_W-1:0] in_raw_discharge_current,
  input  logic                    q_full,
  output logic                    q_push,
  output bclc_pkg::item_t         q_item
);
  import bclc_pkg::*;

  logic              f_vld_r, f_vld_nxt;
  logic [1:0]        last_mode_r, last_mode_nxt;
  logic [1:0]        f_mode_r;
  logic              f_clr_load_r, f_clr_chg_r;
  logic [PROD_W-1:0] prod_v_r, prod_c_r, prod_d_r;
  logic              in_fire;
  logic              mode_chg;

  assign in_ready = !f_vld_r || !q_full;
  assign in_fire  = in_valid && in_ready;
  assign q_push   = f_vld_r && !q_full;
  assign mode_chg = (in_mode != last_mode_r);

  always_comb begin
    f_vld_nxt = f_vld_r;
    if (q_push) begin
      f_vld_nxt = 1'b0;
    end
    if (in_fire) begin
      f_vld_nxt = 1'b1;
    end
    last_mode_nxt = in_fire ? in_mode : last_mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r     <= 1'b0;
      last_mode_r <= MODE_IDLE;
    end else begin
      f_vld_r     <= f_vld_nxt;
      last_mode_r <= last_mode_nxt;
    end
    if (in_fire) begin
      f_mode_r     <= in_mode;
      f_clr_load_r <= mode_chg && (in_mode == MODE_IDLE);
      f_clr_chg_r  <= mode_chg && (in_mode == MODE_OFF);
      prod_v_r     <= PROD_W'(in_raw_voltage) * PROD_W'(SCALE_M_V);
      prod_c_r     <= PROD_W'(in_raw_charge_current) * PROD_W'(SCALE_M_C);
      prod_d_r     <= PROD_W'(in_raw_discharge_current) * PROD_W'(SCALE_M_D);
    end
  end

  always_comb begin
    q_item.volt     = prod_v_r[SCALE_SHIFT +: VAL_W];
    q_item.chg      = prod_c_r[SCALE_SHIFT +: VAL_W];
    q_item.dis      = prod_d_r[SCALE_SHIFT +: VAL_W];
    q_item.mode     = f_mode_r;
    q_item.clr_load = f_clr_load_r;
    q_item.clr_chg  = f_clr_chg_r;
  end

endmodule

// ===== rtl/core/bclc_queue.sv =====
`timescale 1ns / 1ps
// Short item queue between front end and back end.
module bclc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bclc_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output bclc_pkg::item_t head
);
  import bclc_pkg::*;

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/core/bclc_back.sv =====
`timescale 1ns / 1ps
// Back end: averaging ring, charger and load duty stepping, result register.
module bclc_back #(
  parameter int WINDOW_LOG2 = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bclc_pkg::cfg_t    cfg,
  input  logic              q_empty,
  input  bclc_pkg::item_t   q_head,
  output logic              q_pop,
  input  logic              out_ready,
  output logic              out_valid,
  output bclc_pkg::result_t out_res
);
  import bclc_pkg::*;

  localparam int DEPTH = 1 << WINDOW_LOG2;
  localparam int SUM_W = VAL_W + WINDOW_LOG2;
  localparam int RAM_W = 3 * VAL_W;

  typedef enum logic {PH_READ, PH_WRITE} phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [WINDOW_LOG2-1:0] pos_r, pos_nxt;
  logic                   filled_r, filled_nxt;
  logic [SUM_W-1:0]       sum_v_r, sum_c_r, sum_d_r;
  logic [SUM_W-1:0]       sum_v_nxt, sum_c_nxt, sum_d_nxt;

  logic                   s2_vld_r, s2_vld_nxt;
  logic [1:0]             s2_mode_r;
  logic                   s2_clr_load_r, s2_clr_chg_r;
  logic [VAL_W-1:0]       s2_avg_v_r, s2_avg_i_r, s2_avg_d_r;

  logic [DUTY_W-1:0]      charger_r, charger_nxt;
  logic [DUTY_W-1:0]      load_r, load_nxt;
  logic                   det_r, det_nxt;
  logic [WAIT_W-1:0]      wait_r, wait_nxt;
  logic [1:0]             kind;
  logic [DUTY_W-1:0]      cap;

  logic                   out_vld_r, out_vld_nxt;
  result_t                out_res_r;

  logic                   rd_en;
  logic [RAM_W-1:0]       rd_data, wr_data;
  logic [VAL_W-1:0]       old_v, old_c, old_d;
  logic                   c_fire, s2_free;

  bclc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (q_pop),
    .wr_addr (pos_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  assign c_fire  = s2_vld_r && (!out_vld_r || out_ready);
  assign s2_free = !s2_vld_r || c_fire;
  assign rd_en   = (phase_r == PH_READ) && !q_empty;
  assign q_pop   = (phase_r == PH_WRITE) && s2_free;
  assign wr_data = {q_head.volt, q_head.chg, q_head.dis};

  // slots not yet written in the first pass read as zero
  assign old_v = filled_r ? rd_data[2*VAL_W +: VAL_W] : '0;
  assign old_c = filled_r ? rd_data[VAL_W +: VAL_W] : '0;
  assign old_d = filled_r ? rd_data[0 +: VAL_W] : '0;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    filled_nxt = filled_r;
    sum_v_nxt  = sum_v_r - SUM_W'(old_v) + SUM_W'(q_head.volt);
    sum_c_nxt  = sum_c_r - SUM_W'(old_c) + SUM_W'(q_head.chg);
    sum_d_nxt  = sum_d_r - SUM_W'(old_d) + SUM_W'(q_head.dis);
    s2_vld_nxt = c_fire ? 1'b0 : s2_vld_r;
    case (phase_r)
      PH_READ: begin
        if (rd_en) begin
          phase_nxt = PH_WRITE;
        end
      end
      PH_WRITE: begin
        if (q_pop) begin
          phase_nxt  = PH_READ;
          pos_nxt    = pos_r + 1'b1;
          filled_nxt = filled_r || (pos_r == '1);
          s2_vld_nxt = 1'b1;
        end
      end
      default: phase_nxt = PH_READ;
    endcase
  end

  always_comb begin
    cap         = (cfg.pwm_period > CAP_OFFSET) ? cfg.pwm_period - CAP_OFFSET : '0;
    charger_nxt = s2_clr_chg_r ? '0 : charger_r;
    load_nxt    = s2_clr_load_r ? '0 : load_r;
    det_nxt     = det_r;
    wait_nxt    = wait_r;
    kind        = KIND_NONE;
    case (s2_mode_r)
      MODE_CHARGE: begin
        if (s2_avg_v_r < V_DEAD && s2_avg_i_r < I_DEAD) begin
          charger_nxt = '0;
        end
        if (det_r) begin
          if (s2_avg_v_r < V_LI_MAX) begin
            if (charger_nxt < cap && s2_avg_v_r < V_CC_MAX) begin
              if (s2_avg_i_r < VAL_W'(cfg.charge_target)) begin
                charger_nxt = charger_nxt + 1'b1;
              end else if (s2_avg_i_r > VAL_W'(cfg.charge_target) &&
                           charger_nxt != '0) begin
                charger_nxt = charger_nxt - 1'b1;
              end
            end
            if (s2_avg_v_r >= V_CV_LO && s2_avg_v_r < V_CV_HI) begin
              charger_nxt = cfg.cv_hold;
            end
            kind = KIND_LITHIUM;
          end
          if (s2_avg_v_r > V_LI_MAX) begin
            if (s2_avg_v_r < V_SLA_HI) begin
              charger_nxt = cfg.sla_hold;
            end
            kind = KIND_LEAD;
          end
        end
        if (s2_avg_i_r == '0 && s2_avg_v_r < V_DETECT) begin
          charger_nxt = '0;
          wait_nxt    = cfg.detect_wait;
          det_nxt     = 1'b0;
        end else if (wait_r != '0) begin
          wait_nxt = wait_r - 1'b1;
        end else if (s2_avg_v_r > V_DETECT && s2_avg_i_r < I_DETECT) begin
          det_nxt = 1'b1;
        end
      end
      MODE_LOAD: begin
        if (s2_avg_d_r < VAL_W'(cfg.load_target) && load_nxt < cfg.pwm_period) begin
          load_nxt = load_nxt + 1'b1;
        end else if (s2_avg_d_r > VAL_W'(cfg.load_target) && load_nxt != '0) begin
          load_nxt = load_nxt - 1'b1;
        end
        kind = KIND_DISCHARGE;
      end
      default: kind = KIND_NONE;
    endcase
    out_vld_nxt = c_fire ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_READ;
      pos_r     <= '0;
      filled_r  <= 1'b0;
      sum_v_r   <= '0;
      sum_c_r   <= '0;
      sum_d_r   <= '0;
      s2_vld_r  <= 1'b0;
      charger_r <= '0;
      load_r    <= '0;
      det_r     <= 1'b0;
      wait_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      filled_r <= filled_nxt;
      s2_vld_r <= s2_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (q_pop) begin
        sum_v_r <= sum_v_nxt;
        sum_c_r <= sum_c_nxt;
        sum_d_r <= sum_d_nxt;
      end
      if (c_fire) begin
        charger_r <= charger_nxt;
        load_r    <= load_nxt;
        det_r     <= det_nxt;
        wait_r    <= wait_nxt;
      end
    end
    if (q_pop) begin
      s2_mode_r     <= q_head.mode;
      s2_clr_load_r <= q_head.clr_load;
      s2_clr_chg_r  <= q_head.clr_chg;
      s2_avg_v_r    <= sum_v_nxt[WINDOW_LOG2 +: VAL_W];
      s2_avg_i_r    <= sum_c_nxt[WINDOW_LOG2 +: VAL_W];
      s2_avg_d_r    <= sum_d_nxt[WINDOW_LOG2 +: VAL_W];
    end
    if (c_fire) begin
      out_res_r.charge_duty <= charger_nxt;
      out_res_r.load_duty   <= load_nxt;
      out_res_r.present     <= det_nxt;
      out_res_r.avg_mv      <= s2_avg_v_r;
      out_res_r.avg_chg     <= s2_avg_i_r[MA_W-1:0];
      out_res_r.avg_dis     <= s2_avg_d_r[MA_W-1:0];
      out_res_r.kind        <= kind;
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

endmodule

// ===== rtl/core/bclc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the battery charge and load controller, with bind.
module bclc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bclc_pkg::DUTY_W-1:0] out_charge_duty,
  input logic [bclc_pkg::DUTY_W-1:0] out_load_duty,
  input logic                        out_battery_present,
  input logic [1:0]                  out_display_kind
);
  import bclc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_charge_duty) &&
      $stable(out_load_duty))
    else $error("result item changed while stalled");

  a_lost_battery: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_battery_present &&
      (out_display_kind == KIND_LITHIUM || out_display_kind == KIND_LEAD)
      |-> out_charge_duty == '0)
    else $error("charger duty nonzero after battery loss");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind battery_charge_load_controller bclc_checker u_bclc_checker (.*);
